### hdl/occupancy_cell_pooling_assert.svh
// Assertion macros for the occupancy cell pooling block.
// Expects clk and rst_n in the scope of use.
`ifndef OCCUPANCY_CELL_POOLING_ASSERT_SVH
`define OCCUPANCY_CELL_POOLING_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define OCP_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("occupancy_cell_pooling: check failed");

// Trigger implies the consequence in the next cycle.
`define OCP_CHECK_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("occupancy_cell_pooling: sequence check failed");

`endif

### hdl/ocp_pkg.sv
// Shared types and constants for the occupancy cell pooling block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ocp_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_CELL      = 256;

  localparam int CFG_DW = 11;
  localparam int CFG_IW = 2;

  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_CELL_SIZE    = 2'd2;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [8:0]  RST_CELL_SIZE    = 9'd8;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_LW    = $clog2(OFIFO_DEPTH + 1);

  typedef struct packed {
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic       occupied;
    logic       last_cell;
  } res_t;

  // Per-pixel control carried from the scan stage to the flag update stage.
  typedef struct packed {
    logic       first;
    logic       nz;
    logic       emit;
    logic       last;
    logic [9:0] grid_row;
  } s1_t;

endpackage

`default_nettype wire

### hdl/occupancy_cell_pooling.sv
// Occupancy cell pooling: reduces a raster mask stream to one occupancy bit per grid cell.
// One pixel is taken per clock; the flag update stage queues a cell's result with its last
// pixel. One flag per grid column lives in a 1-bit x MAX_WIDTH RAM with a registered read:
// the scan stage reads the column flag, the next stage ORs in the pixel and writes it
// back, with the last write forwarded so neighboring pixels of a cell chain at full rate.
// Results drain through a four-entry queue; the input stalls only while that queue,
// counting a result still in flight, holds more than two entries. The flag RAM needs no
// clearing pass: each cell's first pixel overwrites its flag.
// Depends on ocp_pkg, ocp_scan, ocp_ram, ocp_ofifo, occupancy_cell_pooling_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "occupancy_cell_pooling_assert.svh"

module occupancy_cell_pooling #(
  parameter int MAX_WIDTH = ocp_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [ocp_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [ocp_pkg::CFG_DW-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_pixel_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [9:0]                 out_cell_x,
  output logic      [9:0]                 out_cell_y,
  output logic                            out_occupied,
  output logic                            out_last_cell
);

  logic [10:0]   image_width_r;
  logic [10:0]   image_height_r;
  logic [8:0]    cell_size_r;

  logic          in_accept;
  logic [CW-1:0] rd_col;
  logic          s1_valid;
  ocp_pkg::s1_t  s1;
  logic [CW-1:0] s1_col;
  logic          rd_flag;

  logic          lw_valid_r;
  logic [CW-1:0] lw_addr_r;
  logic          lw_data_r;
  logic          old_flag, flag;

  ocp_pkg::res_t                 push_data, out_data;
  logic                          push;
  logic [ocp_pkg::OFIFO_LW-1:0]  fifo_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= ocp_pkg::RST_IMAGE_WIDTH;
      image_height_r <= ocp_pkg::RST_IMAGE_HEIGHT;
      cell_size_r    <= ocp_pkg::RST_CELL_SIZE;
    end else if (cfg_we) begin
      case (cfg_index)
        ocp_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        ocp_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        ocp_pkg::CFG_CELL_SIZE:    cell_size_r    <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (fifo_level + ocp_pkg::OFIFO_LW'(s1_valid && s1.emit))
                     > ocp_pkg::OFIFO_LW'(ocp_pkg::OFIFO_DEPTH - 2);
  assign in_accept = in_valid && !in_stall;

  ocp_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .nz           (in_pixel_value != 8'd0),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .cell_size    (cell_size_r),
    .rd_col       (rd_col),
    .s1_valid_r   (s1_valid),
    .s1_r         (s1),
    .s1_col_r     (s1_col)
  );

  ocp_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flags (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (flag),
    .re    (in_accept),
    .raddr (rd_col),
    .rdata (rd_flag)
  );

  // Last write forwarded: covers a read issued in the same cycle as the write.
  assign old_flag = (lw_valid_r && (lw_addr_r == s1_col)) ? lw_data_r : rd_flag;
  assign flag     = s1.first ? s1.nz : (old_flag || s1.nz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (s1_valid) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      lw_addr_r <= s1_col;
      lw_data_r <= flag;
    end
  end

  assign push                = s1_valid && s1.emit;
  assign push_data.cell_x    = 10'(s1_col);
  assign push_data.cell_y    = s1.grid_row;
  assign push_data.occupied  = flag;
  assign push_data.last_cell = s1.last;

  ocp_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .level     (fifo_level)
  );

  assign out_cell_x    = out_data.cell_x;
  assign out_cell_y    = out_data.cell_y;
  assign out_occupied  = out_data.occupied;
  assign out_last_cell = out_data.last_cell;

  `OCP_CHECK(a_s1_follows_accept, !s1_valid || $past(in_accept))
  `OCP_CHECK(a_queue_bounded, fifo_level <= ocp_pkg::OFIFO_LW'(ocp_pkg::OFIFO_DEPTH))
  `OCP_CHECK_NEXT(a_result_queued, push, fifo_level != '0)

endmodule

`default_nettype wire

### hdl/ocp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ocp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/ocp_scan.sv
// Raster scan counters: pixel, in-cell and grid positions, cell end detection.
// Depends on ocp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocp_scan #(
  parameter int MAX_WIDTH = ocp_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic         nz,
  input  wire logic [10:0]  image_width,
  input  wire logic [10:0]  image_height,
  input  wire logic [8:0]   cell_size,
  output logic      [CW-1:0] rd_col,
  output logic              s1_valid_r,
  output ocp_pkg::s1_t      s1_r,
  output logic      [CW-1:0] s1_col_r
);

  localparam int EW = (CW + 1 > 11) ? CW + 1 : 11;

  logic [CW-1:0] pcol_r, pcol_nxt;
  logic [9:0]    prow_r, prow_nxt;
  logic [7:0]    cic_r, cic_nxt;
  logic [7:0]    ric_r, ric_nxt;
  logic [CW-1:0] gcol_r, gcol_nxt;
  logic [9:0]    grow_r, grow_nxt;

  logic [EW-1:0] w_ext;
  logic [CW-1:0] w_m1;
  logic [9:0]    h_m1;
  logic [7:0]    cs_m1;
  logic          row_end, frame_end, cell_col_end, cell_row_end;

  assign w_ext = EW'(image_width);

  always_comb begin
    if (image_width == 11'd0) begin
      w_m1 = '0;
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(w_ext - EW'(1));
    end
    if (image_height == 11'd0) begin
      h_m1 = '0;
    end else if (image_height > 11'(ocp_pkg::MAX_HEIGHT)) begin
      h_m1 = 10'(ocp_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = 10'(image_height - 11'd1);
    end
    if (cell_size == 9'd0) begin
      cs_m1 = '0;
    end else if (cell_size > 9'(ocp_pkg::MAX_CELL)) begin
      cs_m1 = 8'(ocp_pkg::MAX_CELL - 1);
    end else begin
      cs_m1 = 8'(cell_size - 9'd1);
    end
  end

  assign row_end      = pcol_r >= w_m1;
  assign frame_end    = prow_r >= h_m1;
  assign cell_col_end = row_end || (cic_r >= cs_m1);
  assign cell_row_end = frame_end || (ric_r >= cs_m1);
  assign rd_col       = gcol_r;

  always_comb begin
    pcol_nxt = pcol_r;
    prow_nxt = prow_r;
    cic_nxt  = cic_r;
    ric_nxt  = ric_r;
    gcol_nxt = gcol_r;
    grow_nxt = grow_r;
    if (accept) begin
      if (row_end) begin
        pcol_nxt = '0;
        cic_nxt  = '0;
        gcol_nxt = '0;
        if (frame_end) begin
          prow_nxt = '0;
          ric_nxt  = '0;
          grow_nxt = '0;
        end else begin
          prow_nxt = prow_r + 10'd1;
          if (cell_row_end) begin
            ric_nxt  = '0;
            grow_nxt = grow_r + 10'd1;
          end else begin
            ric_nxt = ric_r + 8'd1;
          end
        end
      end else begin
        pcol_nxt = pcol_r + CW'(1);
        if (cell_col_end) begin
          cic_nxt  = '0;
          gcol_nxt = gcol_r + CW'(1);
        end else begin
          cic_nxt = cic_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcol_r     <= '0;
      prow_r     <= '0;
      cic_r      <= '0;
      ric_r      <= '0;
      gcol_r     <= '0;
      grow_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      pcol_r     <= pcol_nxt;
      prow_r     <= prow_nxt;
      cic_r      <= cic_nxt;
      ric_r      <= ric_nxt;
      gcol_r     <= gcol_nxt;
      grow_r     <= grow_nxt;
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.first    <= (ric_r == 8'd0) && (cic_r == 8'd0);
      s1_r.nz       <= nz;
      s1_r.emit     <= cell_col_end && cell_row_end;
      s1_r.last     <= row_end && frame_end;
      s1_r.grid_row <= grow_r;
      s1_col_r      <= gcol_r;
    end
  end

endmodule

`default_nettype wire

### hdl/ocp_ofifo.sv
// Small result queue between the flag update stage and the output channel.
// Depends on ocp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ocp_ofifo (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire ocp_pkg::res_t             push_data,
  input  wire logic                      out_stall,
  output logic                           out_valid,
  output ocp_pkg::res_t                  out_data,
  output logic [ocp_pkg::OFIFO_LW-1:0]   level
);

  ocp_pkg::res_t                   mem_r [ocp_pkg::OFIFO_DEPTH];
  logic [ocp_pkg::OFIFO_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [ocp_pkg::OFIFO_LW-1:0]    level_r, level_nxt;
  logic                            pop;

  assign out_valid = level_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign level     = level_r;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + ocp_pkg::OFIFO_LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - ocp_pkg::OFIFO_LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + ocp_pkg::OFIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + ocp_pkg::OFIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### bench/tb_occupancy_cell_pooling.sv
// Self-checking bench for occupancy_cell_pooling: directed rows, then random mask streams
// under random register settings, checked against a behavioral pooling predictor.
// Depends on ocp_pkg and the occupancy_cell_pooling RTL.
`timescale 1ns / 1ps

module tb_occupancy_cell_pooling;

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX = 10;
  localparam logic [ocp_pkg::CFG_IW-1:0] CFG_SPARE = 2'd3;
  localparam ocp_pkg::res_t NO_CELL = '0;

  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic [1:0]    idx;
    logic [10:0]   data;
    bit            chk;
    ocp_pkg::res_t exp_res;
  } dir_row_t;

  typedef struct {
    bit            chk;
    ocp_pkg::res_t exp_res;
  } pix_tag_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [ocp_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [ocp_pkg::CFG_DW-1:0] cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 in_pixel_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [9:0]                 out_cell_x;
  logic [9:0]                 out_cell_y;
  logic                       out_occupied;
  logic                       out_last_cell;

  occupancy_cell_pooling i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_value(in_pixel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_occupied  (out_occupied),
    .out_last_cell (out_last_cell)
  );

  always #6 clk = ~clk;

  // Pooling predictor state
  logic [10:0] pool_w = ocp_pkg::RST_IMAGE_WIDTH;
  logic [10:0] pool_h = ocp_pkg::RST_IMAGE_HEIGHT;
  logic [8:0]  pool_cs = ocp_pkg::RST_CELL_SIZE;
  bit          band_flag [ocp_pkg::MAX_WIDTH_DEF];
  // columns never written since reset hold an undefined flag in the RAM
  bit          band_known [ocp_pkg::MAX_WIDTH_DEF];
  int unsigned px_col = 0, px_row = 0, in_col = 0, in_row = 0, gcol = 0, grow = 0;

  ocp_pkg::res_t cell_q [$];
  bit            known_q [$];
  pix_tag_t      pix_tags [$];

  int unsigned err_cnt = 0;
  int unsigned n_pix = 0, n_cells = 0, n_occ = 0, n_frames = 0, n_writes = 0;
  int unsigned quiet = 0;
  int unsigned burst_left = 0;
  bit          sending = 1'b0;
  bit          hold_req = 1'b0;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit pool_pixel(input logic [7:0] px, output ocp_pkg::res_t res,
                                    output bit occ_known);
    int unsigned w, h, cs;
    bit nz, row_end, frame_end, col_end, rowc_end, flag;
    w = clampu(pool_w, 1, ocp_pkg::MAX_WIDTH_DEF);
    h = clampu(pool_h, 1, ocp_pkg::MAX_HEIGHT);
    cs = clampu(pool_cs, 1, ocp_pkg::MAX_CELL);
    nz = (px != 8'd0);
    row_end = px_col >= w - 1;
    frame_end = px_row >= h - 1;
    col_end = row_end || in_col >= cs - 1;
    rowc_end = frame_end || in_row >= cs - 1;
    if (gcol < ocp_pkg::MAX_WIDTH_DEF) begin
      if (in_row == 0 && in_col == 0) begin
        flag = nz;
        occ_known = 1'b1;
      end else begin
        flag = band_flag[gcol] | nz;
        occ_known = band_known[gcol] | nz;
      end
      band_flag[gcol] = flag;
      band_known[gcol] = occ_known;
    end else begin
      flag = nz;
      occ_known = 1'b1;
    end
    res.cell_x = 10'(gcol);
    res.cell_y = 10'(grow);
    res.occupied = flag;
    res.last_cell = row_end && frame_end;
    if (row_end) begin
      px_col = 0;
      in_col = 0;
      gcol = 0;
      if (frame_end) begin
        px_row = 0;
        in_row = 0;
        grow = 0;
      end else begin
        px_row++;
        if (rowc_end) begin
          in_row = 0;
          grow++;
        end else begin
          in_row++;
        end
      end
    end else begin
      px_col++;
      if (col_end) begin
        in_col = 0;
        gcol++;
      end else begin
        in_col++;
      end
    end
    return col_end && rowc_end;
  endfunction

  // pixels still needed to close the current frame
  function automatic int unsigned frame_left();
    int unsigned w, h, row_rest, rows_after;
    w = clampu(pool_w, 1, ocp_pkg::MAX_WIDTH_DEF);
    h = clampu(pool_h, 1, ocp_pkg::MAX_HEIGHT);
    row_rest = (px_col >= w - 1) ? 1 : w - px_col;
    rows_after = (px_row >= h - 1) ? 0 : h - 1 - px_row;
    return row_rest + rows_after * w;
  endfunction

  // Observes every transfer on all ports at the clock edge
  always @(posedge clk) begin : scoreboard
    pix_tag_t      tag;
    ocp_pkg::res_t pred;
    ocp_pkg::res_t want;
    bit            got;
    bit            known;
    bit            want_known;
    if (rst_n) begin
      if (cfg_we) begin
        n_writes++;
        case (cfg_index)
          ocp_pkg::CFG_IMAGE_WIDTH:  pool_w = cfg_wdata[10:0];
          ocp_pkg::CFG_IMAGE_HEIGHT: pool_h = cfg_wdata[10:0];
          ocp_pkg::CFG_CELL_SIZE:    pool_cs = cfg_wdata[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        tag = pix_tags.pop_front();
        got = pool_pixel(in_pixel_value, pred, known);
        n_pix++;
        if (tag.chk) begin
          cell_q.push_back(tag.exp_res);
          known_q.push_back(1'b1);
        end else if (got) begin
          cell_q.push_back(pred);
          known_q.push_back(known);
        end
      end
      if (out_valid && !out_stall) begin
        n_cells++;
        if (out_occupied === 1'b1) n_occ++;
        if (out_last_cell === 1'b1) n_frames++;
        if (cell_q.size() == 0) begin
          if (err_cnt < REPORT_MAX)
            $display("[%0t] unexpected cell x=%0d y=%0d occ=%0b last=%0b", $realtime,
                     out_cell_x, out_cell_y, out_occupied, out_last_cell);
          err_cnt++;
        end else begin
          want = cell_q.pop_front();
          want_known = known_q.pop_front();
          if (out_cell_x !== want.cell_x || out_cell_y !== want.cell_y ||
              (want_known && out_occupied !== want.occupied) ||
              out_last_cell !== want.last_cell) begin
            if (err_cnt < REPORT_MAX)
              $display("[%0t] cell mismatch: exp x=%0d y=%0d occ=%0b last=%0b,",
                       $realtime, want.cell_x, want.cell_y, want.occupied, want.last_cell,
                       " got x=%0d y=%0d occ=%0b last=%0b",
                       out_cell_x, out_cell_y, out_occupied, out_last_cell);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode, left, tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 120);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (tick % 4 != 0);
        endcase
      end
    end
  end

  task automatic send_pixel(input logic [7:0] px, input bit chk,
                            input ocp_pkg::res_t exp_res);
    pix_tag_t tag;
    int unsigned gap;
    tag.chk = chk;
    tag.exp_res = exp_res;
    pix_tags.push_back(tag);
    in_valid <= 1'b1;
    in_pixel_value <= px;
    sending = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    while (pix_tags.size() != 0 || cell_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ocp_pkg::CFG_IW-1:0] idx,
                           input logic [ocp_pkg::CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  dir_row_t dir_tab [32] = '{
    '{ROW_PIX, 2'd0, 11'h0FF, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_WIDTH, 11'd1, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_HEIGHT, 11'd1, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},          // counters past the new bounds
    '{ROW_CFG, ocp_pkg::CFG_CELL_SIZE, 11'd1, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b1}},
    '{ROW_PIX, 2'd0, 11'h0FF, 1'b1, '{10'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_PIX, 2'd0, 11'h001, 1'b1, '{10'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_PIX, 2'd0, 11'h080, 1'b1, '{10'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_WIDTH, 11'd0, 1'b0, NO_CELL},   // zero settings clamp to one
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_HEIGHT, 11'd0, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_CELL_SIZE, 11'd0, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b1}},
    '{ROW_PIX, 2'd0, 11'h05A, 1'b1, '{10'd0, 10'd0, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_SPARE, 11'h7FF, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_WIDTH, 11'd3, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_HEIGHT, 11'd2, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_CELL_SIZE, 11'h202, 1'b0, NO_CELL},   // upper bits dropped, size 2
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h007, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b1, '{10'd0, 10'd0, 1'b0, 1'b0}},
    '{ROW_PIX, 2'd0, 11'h000, 1'b1, '{10'd1, 10'd0, 1'b1, 1'b1}},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_WIDTH, 11'd5, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_IMAGE_HEIGHT, 11'd1, 1'b0, NO_CELL},
    '{ROW_CFG, ocp_pkg::CFG_CELL_SIZE, 11'h1FF, 1'b0, NO_CELL},   // above max, clamps to 256
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h020, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h000, 1'b0, NO_CELL},
    '{ROW_PIX, 2'd0, 11'h040, 1'b1, '{10'd0, 10'd0, 1'b1, 1'b1}}
  };

  initial begin : stimulus
    int unsigned n_rand, len, dens, left;
    bit          wide, wide_done, tall_done;
    logic [7:0]  px;
    n_rand = 0;
    wide_done = 1'b0;
    tall_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (i == 0 || dir_tab[i-1].kind == ROW_PIX) wait_idle();
        cfg_write(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].data[7:0], dir_tab[i].chk, dir_tab[i].exp_res);
      end
    end

    while (n_rand < RANDOM_ITEMS) begin
      wait_idle();
      if (!wide_done && n_rand >= 500) begin
        // full-width frame, one pixel per cell, with a long output hold-off
        cfg_write(ocp_pkg::CFG_IMAGE_WIDTH, 11'h7FF);
        cfg_write(ocp_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        cfg_write(ocp_pkg::CFG_CELL_SIZE, 11'd1);
        len = frame_left() + ocp_pkg::MAX_WIDTH_DEF;
        dens = 50;
        hold_req = 1'b1;
        wide_done = 1'b1;
      end else if (!tall_done && n_rand >= 1200) begin
        cfg_write(ocp_pkg::CFG_IMAGE_WIDTH, 11'd1);
        cfg_write(ocp_pkg::CFG_IMAGE_HEIGHT, 11'h450);
        cfg_write(ocp_pkg::CFG_CELL_SIZE, 11'd0);
        len = 40;
        dens = 30;
        tall_done = 1'b1;
      end else begin
        wide = ($urandom_range(0, 6) == 0);
        if ($urandom_range(0, 1))
          cfg_write(ocp_pkg::CFG_IMAGE_WIDTH,
                    wide ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(1, 24)));
        if ($urandom_range(0, 1))
          cfg_write(ocp_pkg::CFG_IMAGE_HEIGHT,
                    wide ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 16)));
        if ($urandom_range(0, 1))
          cfg_write(ocp_pkg::CFG_CELL_SIZE,
                    wide ? 11'($urandom_range(0, 2047)) : 11'($urandom_range(0, 8)));
        left = frame_left();
        len = ($urandom_range(0, 9) < 6 && left <= 600) ? left : $urandom_range(1, 40);
        case ($urandom_range(0, 4))
          0: dens = 0;
          1: dens = 10;
          2: dens = 30;
          3: dens = 60;
          default: dens = 100;
        endcase
      end
      repeat (len) begin
        px = ($urandom_range(0, 99) < dens) ? 8'($urandom_range(1, 255)) : 8'd0;
        send_pixel(px, 1'b0, NO_CELL);
        n_rand++;
      end
    end

    wait_idle();
    err_cnt += cell_q.size();
    $display("Streamed %0d pixels, %0d register writes, incl. full-width and tall frames",
             n_pix, n_writes);
    $display("Checked %0d cells: %0d occupied, %0d frame ends", n_cells, n_occ, n_frames);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
